// File: rtl/spra_pkg.sv
// Package of the strict-priority round-robin switch allocator.
// Holds widths, register indexes, shared types and small helper functions.
// No dependencies.
`default_nettype none

package spra_pkg;

    localparam int LANE_MAX      = 4;
    localparam int LANE_W        = 2;
    localparam int MASK_W        = 16;
    localparam int SLOT_W        = 4;
    localparam int CNT_W         = 5;
    localparam int PHASE_W       = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = LANE_MAX * MASK_W;
    localparam int OUT_DATA_W    = 8;
    localparam int NUM_LANES_DEF = 4;
    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_VL0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_VL1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_VL2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_VL3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_BASE = 3'd4;

    localparam logic [CNT_W-1:0] SLOTS_RESET = 5'd16;

    typedef logic [LANE_MAX-1:0][CNT_W-1:0]  t_slots;
    typedef logic [LANE_MAX-1:0][MASK_W-1:0] t_lanes;

    typedef struct packed {
        logic   valid;
        t_lanes elig;
    } t_item;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] dividend;
        logic [CNT_W-1:0]   divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } t_mod_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANE,
        ST_MOD,
        ST_FIN
    } t_state;

    function automatic logic [CNT_W-1:0] f_cap_count(input logic [CNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] lim);
        return (c > lim) ? lim : c;
    endfunction

    function automatic logic [MASK_W-1:0] f_count_mask(input logic [CNT_W-1:0] c);
        logic [MASK_W-1:0] m;
        for (int s = 0; s < MASK_W; s++) begin
            m[s] = (CNT_W'(s) < c);
        end
        return m;
    endfunction

    function automatic logic [SLOT_W-1:0] f_lowest(input logic [MASK_W-1:0] m);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int s = MASK_W - 1; s >= 0; s--) begin
            if (m[s]) begin
                r = SLOT_W'(s);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/spra_mod.sv
// Serial remainder unit: restoring division, one dividend bit per cycle.
// Depends on spra_pkg.
`default_nettype none

module spra_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spra_pkg::t_mod_req i_req,
    output spra_pkg::t_mod_rsp     o_rsp
);

    localparam logic [3:0] LastStep = 4'(spra_pkg::PHASE_W - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_step;
    logic [spra_pkg::CNT_W-1:0]   r_rem;
    logic [spra_pkg::PHASE_W-1:0] r_dvd;
    logic [spra_pkg::CNT_W-1:0]   r_dsr;
    logic [spra_pkg::CNT_W-1:0]   trial;
    logic [spra_pkg::CNT_W-1:0]   n_rem;

    assign trial = {r_rem[spra_pkg::CNT_W-2:0], r_dvd[spra_pkg::PHASE_W-1]};
    assign n_rem = (trial >= r_dsr) ? trial - r_dsr : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= LastStep;
            end else if (r_busy) begin
                r_step <= r_step - 4'd1;
                if (r_step == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[spra_pkg::PHASE_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[spra_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/spra_front.sv
// Front end: accepts request beats, masks each lane to its slot count and
// queues them in a two-entry queue for the back end. Depends on spra_pkg.
`default_nettype none

module spra_front #(
    parameter int NUM_SLOTS = spra_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [spra_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire spra_pkg::t_slots                 i_slots,
    output spra_pkg::t_item                       o_item,
    input  wire logic                             i_pop
);

    localparam int SlotLim = (NUM_SLOTS < spra_pkg::MASK_W) ? NUM_SLOTS : spra_pkg::MASK_W;
    localparam logic [spra_pkg::CNT_W-1:0] LimCnt = spra_pkg::CNT_W'(SlotLim);
    localparam logic [1:0] QDepth = 2'd2;

    spra_pkg::t_lanes r_q [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_fill;
    spra_pkg::t_lanes masked;
    logic             push;

    always_comb begin
        for (int l = 0; l < spra_pkg::LANE_MAX; l++) begin
            masked[l] = i_s_tdata[l*spra_pkg::MASK_W +: spra_pkg::MASK_W]
                      & spra_pkg::f_count_mask(spra_pkg::f_cap_count(i_slots[l], LimCnt));
        end
    end

    assign o_s_tready = (r_fill != QDepth);
    assign push       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= masked;
        end
    end

    assign o_item.valid = (r_fill != 2'd0);
    assign o_item.elig  = r_q[r_rd];

endmodule

`default_nettype wire

// File: rtl/spra_back.sv
// Back end: lane sequencer with round-robin pointers, seeding through the
// serial remainder unit, and the result register. Depends on spra_pkg.
`default_nettype none

module spra_back #(
    parameter int NUM_LANES = spra_pkg::NUM_LANES_DEF,
    parameter int NUM_SLOTS = spra_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spra_pkg::t_item                   i_item,
    output logic                                   o_pop,
    input  wire spra_pkg::t_slots                  i_slots,
    input  wire logic [spra_pkg::PHASE_W-1:0]      i_phase,
    output spra_pkg::t_mod_req                     o_mod_req,
    input  wire spra_pkg::t_mod_rsp                i_mod_rsp,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [spra_pkg::OUT_DATA_W-1:0]        o_m_tdata
);

    localparam int LaneCnt = (NUM_LANES < spra_pkg::LANE_MAX) ? NUM_LANES : spra_pkg::LANE_MAX;
    localparam int IdxW    = (LaneCnt > 1) ? $clog2(LaneCnt) : 1;
    localparam int SlotLim = (NUM_SLOTS < spra_pkg::MASK_W) ? NUM_SLOTS : spra_pkg::MASK_W;
    localparam logic [spra_pkg::CNT_W-1:0] LimCnt   = spra_pkg::CNT_W'(SlotLim);
    localparam logic [IdxW-1:0]            LastLane = IdxW'(LaneCnt - 1);

    spra_pkg::t_state             r_state, n_state;
    logic [IdxW-1:0]              r_lane, n_lane;
    logic [spra_pkg::SLOT_W-1:0]  r_ptr [LaneCnt];
    logic [spra_pkg::SLOT_W-1:0]  n_ptr [LaneCnt];
    logic [LaneCnt-1:0]           r_seeded, n_seeded;
    logic                         r_res_valid, n_res_valid;
    logic [spra_pkg::LANE_W-1:0]  r_res_lane, n_res_lane;
    logic [spra_pkg::SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic                         r_out_valid, n_out_valid;
    logic [spra_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [spra_pkg::LANE_W-1:0]  lane_sel;
    logic [spra_pkg::CNT_W-1:0]   cur_cnt;
    logic [spra_pkg::SLOT_W-1:0]  cur_ptr;
    logic [spra_pkg::MASK_W-1:0]  cur_mask;
    logic [spra_pkg::MASK_W-1:0]  hi_mask;
    logic [spra_pkg::SLOT_W-1:0]  pick;
    logic [spra_pkg::CNT_W-1:0]   pick_inc;
    logic [spra_pkg::SLOT_W-1:0]  next_ptr;
    logic                         need_mod;
    logic                         last_lane;
    logic                         out_free;

    assign lane_sel  = spra_pkg::LANE_W'(r_lane);
    assign cur_cnt   = spra_pkg::f_cap_count(i_slots[lane_sel], LimCnt);
    assign cur_ptr   = r_ptr[r_lane];
    assign cur_mask  = i_item.elig[lane_sel];
    assign need_mod  = !r_seeded[r_lane] || ({1'b0, cur_ptr} >= cur_cnt);
    assign hi_mask   = cur_mask & ~((spra_pkg::MASK_W'(1) << cur_ptr) - spra_pkg::MASK_W'(1));
    assign pick      = (hi_mask != '0) ? spra_pkg::f_lowest(hi_mask)
                                       : spra_pkg::f_lowest(cur_mask);
    assign pick_inc  = {1'b0, pick} + spra_pkg::CNT_W'(1);
    assign next_ptr  = (pick_inc == cur_cnt) ? '0 : pick_inc[spra_pkg::SLOT_W-1:0];
    assign last_lane = (r_lane == LastLane);
    assign out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            spra_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_state = spra_pkg::ST_LANE;
                end
            end
            spra_pkg::ST_LANE: begin
                if (cur_cnt == '0) begin
                    n_state = last_lane ? spra_pkg::ST_FIN : spra_pkg::ST_LANE;
                end else if (need_mod) begin
                    n_state = spra_pkg::ST_MOD;
                end else if (cur_mask != '0) begin
                    n_state = spra_pkg::ST_FIN;
                end else begin
                    n_state = last_lane ? spra_pkg::ST_FIN : spra_pkg::ST_LANE;
                end
            end
            spra_pkg::ST_MOD: begin
                if (i_mod_rsp.done) begin
                    n_state = spra_pkg::ST_LANE;
                end
            end
            spra_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = spra_pkg::ST_IDLE;
                end
            end
            default: n_state = spra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_lane      = r_lane;
        n_ptr       = r_ptr;
        n_seeded    = r_seeded;
        n_res_valid = r_res_valid;
        n_res_lane  = r_res_lane;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        o_mod_req.start    = 1'b0;
        o_mod_req.dividend = r_seeded[r_lane] ? spra_pkg::PHASE_W'(cur_ptr) : i_phase;
        o_mod_req.divisor  = cur_cnt;
        case (r_state)
            spra_pkg::ST_IDLE: begin
                n_lane      = '0;
                n_res_valid = 1'b0;
                n_res_lane  = '0;
                n_res_slot  = '0;
            end
            spra_pkg::ST_LANE: begin
                if (cur_cnt != '0 && need_mod) begin
                    o_mod_req.start = 1'b1;
                end else if (cur_cnt != '0 && cur_mask != '0) begin
                    n_res_valid   = 1'b1;
                    n_res_lane    = lane_sel;
                    n_res_slot    = pick;
                    n_ptr[r_lane] = next_ptr;
                end else if (!last_lane) begin
                    n_lane = r_lane + IdxW'(1);
                end
            end
            spra_pkg::ST_MOD: begin
                if (i_mod_rsp.done) begin
                    n_ptr[r_lane]    = i_mod_rsp.rem;
                    n_seeded[r_lane] = 1'b1;
                end
            end
            spra_pkg::ST_FIN: begin
                if (out_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_res_slot, r_res_lane, r_res_valid};
                end
            end
            default: begin
                n_lane = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spra_pkg::ST_IDLE;
            r_lane      <= '0;
            r_seeded    <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LaneCnt; l++) begin
                r_ptr[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_valid <= n_res_valid;
        r_res_lane  <= n_res_lane;
        r_res_slot  <= n_res_slot;
        r_out_data  <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/strict_priority_rr_switch_allocator_unit.sv
// Requests are handled one at a time by the lane sequencer; each lane that is seeded or whose
// pointer is reduced also waits on the bit-serial remainder unit. A two-entry queue and the
// result register let both sides stall on their own, so a new request beat can be taken
// while the back end still works on the last one.
// Reset is synchronous and active low: pointers, seed flags, queue and result beat clear,
// slot counts return to 16 and the phase base to zero.
`default_nettype none

module strict_priority_rr_switch_allocator_unit #(
    parameter int NUM_LANES = spra_pkg::NUM_LANES_DEF,
    parameter int NUM_SLOTS = spra_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // eligible_vl0 [15:0], eligible_vl1 [31:16], eligible_vl2 [47:32], eligible_vl3 [63:48]
    input  wire logic [spra_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // grant_valid [0], grant_lane [2:1], grant_slot [6:3], zero [7]
    output logic [spra_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [spra_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [spra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    spra_pkg::t_slots              r_slots;
    logic [spra_pkg::PHASE_W-1:0]  r_phase;
    spra_pkg::t_item               item;
    logic                          pop;
    spra_pkg::t_mod_req            mod_req;
    spra_pkg::t_mod_rsp            mod_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < spra_pkg::LANE_MAX; l++) begin
                r_slots[l] <= spra_pkg::SLOTS_RESET;
            end
            r_phase <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < spra_pkg::REG_PHASE_BASE) begin
                r_slots[i_cfg_idx[spra_pkg::LANE_W-1:0]] <= i_cfg_data[spra_pkg::CNT_W-1:0];
            end else if (i_cfg_idx == spra_pkg::REG_PHASE_BASE) begin
                r_phase <= i_cfg_data;
            end
        end
    end

    spra_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_slots    (r_slots),
        .o_item     (item),
        .i_pop      (pop)
    );

    spra_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    spra_back #(
        .NUM_LANES (NUM_LANES),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .o_pop      (pop),
        .i_slots    (r_slots),
        .i_phase    (r_phase),
        .o_mod_req  (mod_req),
        .i_mod_rsp  (mod_rsp),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/spra_checker.sv
// Port checker for the switch allocator, attached to the top level by bind.
// Depends on spra_pkg and strict_priority_rr_switch_allocator_unit.
`default_nettype none

module spra_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [spra_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not empty or input not ready after reset");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[6:1] == 6'd0)
        else $error("lane or slot set on a beat without a grant");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[7])
        else $error("padding bit set on a result beat");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind strict_priority_rr_switch_allocator_unit spra_checker u_spra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
